// ----- rtl/disturbance_waveform_summer_top_assert.svh -----
// assertion macros shared by the summer rtl
`ifndef DISTURBANCE_WAVEFORM_SUMMER_TOP_ASSERT_SVH
`define DISTURBANCE_WAVEFORM_SUMMER_TOP_ASSERT_SVH

// same-cycle implication
`define DWS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DWS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/dws_pkg.sv -----
`timescale 1ns / 1ps
package dws_pkg;

  localparam int unsigned PaddrW = 6;
  localparam logic [31:0] LfsrMask = 32'hD000_0001;
  localparam logic [31:0] LfsrSeed = 32'h0000_ACE1;
  localparam longint PiHalfQ30 = 64'sd1686629713;
  localparam logic [15:0] ThreshReset = 16'd1;

  typedef enum logic [2:0] {
    REG_COUNT  = 3'd0,
    REG_CHAN0  = 3'd1,
    REG_CHAN1  = 3'd2,
    REG_CHAN2  = 3'd3,
    REG_CHAN3  = 3'd4,
    REG_THRESH = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_RANDOM = 2'd2,
    WAVE_NONE   = 2'd3
  } wave_e;

  typedef logic [57:0] setup_t;

endpackage

// ----- rtl/dws_cfg.sv -----
`timescale 1ns / 1ps
module dws_cfg import dws_pkg::*; #(
  parameter int N_CHANNELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [63:0]       pwdata_i,
  output logic [63:0]       prdata_o,
  output logic [2:0]        channel_count_o,
  output setup_t            setup_o [N_CHANNELS],
  output logic [15:0]       threshold_o
);

  logic     wr_en;
  reg_idx_e idx;
  logic [2:0]  count_q;
  logic [15:0] thresh_q;
  setup_t      setup_q [4];

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      thresh_q <= ThreshReset;
    end else if (wr_en) begin
      case (idx)
        REG_COUNT:  count_q  <= pwdata_i[2:0];
        REG_THRESH: thresh_q <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  // setups of channels that do not exist stay at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 4; c++) setup_q[c] <= '0;
    end else if (wr_en) begin
      for (int c = 0; c < 4; c++) begin
        if (c < N_CHANNELS && idx == reg_idx_e'(REG_CHAN0 + 3'(c))) begin
          setup_q[c] <= pwdata_i[57:0];
        end
      end
    end
  end

  // channels past the register file run with an all-zero setup
  for (genvar c = 0; c < N_CHANNELS; c++) begin : g_out
    if (c < 4) begin : g_map
      assign setup_o[c] = setup_q[c];
    end else begin : g_zero
      assign setup_o[c] = '0;
    end
  end

  always_comb begin
    case (idx)
      REG_COUNT:  prdata_o = {61'd0, count_q};
      REG_CHAN0:  prdata_o = {6'd0, setup_q[0]};
      REG_CHAN1:  prdata_o = {6'd0, setup_q[1]};
      REG_CHAN2:  prdata_o = {6'd0, setup_q[2]};
      REG_CHAN3:  prdata_o = {6'd0, setup_q[3]};
      REG_THRESH: prdata_o = {48'd0, thresh_q};
      default:    prdata_o = '0;
    endcase
  end

  assign channel_count_o = count_q;
  assign threshold_o     = thresh_q;

endmodule

// ----- rtl/disturbance_waveform_summer_top.sv -----
`timescale 1ns / 1ps
// disturbance waveform summer
// slave stream: one tick item per accept, tdata = {external_level, elapsed_ms}.
// master stream: total_level in tdata[18:0], sent only when it moved by more
// than change_threshold from the last total sent.
// apb port: 64-bit data, register i at byte address 8*i, pready tied high.
// channels are walked one after another by a sequencer around one shared
// 21x18 multiplier and a one-bit-per-cycle restoring divider. each channel
// is loaded, then its value is added to the running sum. in between, a sine
// channel with nonzero p0 runs 32 + log2(4*SINE_TABLE_DEPTH) divide steps,
// a table read, a multiply and a rounding; a random redraw runs two draws,
// each of 16 lfsr steps, a multiply and a result step; square, unused type,
// or no redraw add nothing more. a final state follows the last channel, and
// s_axis_tready is low throughout. a result sits in an output register; the
// next tick is taken while it waits, and only a second result stalls in the final state.
// reset clears all channel state, sets the lfsr to 0xACE1, threshold to 1.
// SINE_TABLE_DEPTH must be a power of two.
module disturbance_waveform_summer_top import dws_pkg::*; #(
  parameter int N_CHANNELS       = 4,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [31:0]       s_axis_tdata_i,  // [15:0] elapsed_ms, [31:16] external_level
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,  // [18:0] total_level
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [63:0]       pwdata_i,
  output logic [63:0]       prdata_o,
  output logic              pready_o
);

  `include "disturbance_waveform_summer_top_assert.svh"

  localparam int D    = SINE_TABLE_DEPTH;
  localparam int DW   = $clog2(D);
  localparam int QW   = $clog2(4 * D);
  localparam int DIVN = 32 + QW;
  localparam int KW   = $clog2(DIVN);
  localparam int CNW  = $clog2(N_CHANNELS + 1);
  localparam int CIW  = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1;
  localparam int SW   = 22;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DIV, ST_ROM, ST_SMUL, ST_SRND,
    ST_DRAW, ST_RMUL, ST_RRES, ST_NEXT, ST_FINAL
  } state_e;

  logic [2:0]  channel_count;
  setup_t      setup [N_CHANNELS];
  logic [15:0] threshold;

  dws_cfg #(.N_CHANNELS(N_CHANNELS)) u_cfg (
    .clk_i, .rst_ni, .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o,
    .channel_count_o(channel_count), .setup_o(setup), .threshold_o(threshold)
  );
  assign pready_o = 1'b1;

  // quarter-wave table, fixed at elaboration, q30 taylor series scaled to 32768
  logic [16:0] sine_rom [D + 1];
  for (genvar k = 0; k <= D; k++) begin : g_rom
    localparam longint Q30 = 64'sd1 << 30;
    localparam longint X  = (PiHalfQ30 * longint'(k)) / SINE_TABLE_DEPTH;
    localparam longint T1 = -((((X * X) / Q30) * X) / Q30) / 6;
    localparam longint T2 = -((((T1 * X) / Q30) * X) / Q30) / 20;
    localparam longint T3 = -((((T2 * X) / Q30) * X) / Q30) / 42;
    localparam longint T4 = -((((T3 * X) / Q30) * X) / Q30) / 72;
    localparam longint T5 = -((((T4 * X) / Q30) * X) / Q30) / 110;
    localparam longint T6 = -((((T5 * X) / Q30) * X) / Q30) / 156;
    localparam longint T7 = -((((T6 * X) / Q30) * X) / Q30) / 210;
    localparam longint T8 = -((((T7 * X) / Q30) * X) / Q30) / 272;
    localparam longint S0 = X + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8;
    localparam longint S1 = (S0 < 0) ? 64'sd0 : S0;
    localparam longint E  = (S1 * 32768 + (64'sd1 << 29)) / Q30;
    assign sine_rom[k] = (E > 32768) ? 17'd32768 : 17'(E);
  end

  state_e              state_q;
  logic [CNW-1:0]      chan_q, n_q;
  logic [15:0]         elapsed_q;
  logic signed [SW-1:0] sum_q;
  logic [31:0]         time_q [N_CHANNELS];
  logic signed [15:0]  val_q [N_CHANNELS];
  logic [20:0]         intv_q [N_CHANNELS];
  logic signed [18:0]  last_q, out_q;
  logic                m_valid_q;
  logic [31:0]         lfsr_q;
  logic [31:0]         div_t_q;
  logic [19:0]         rem_q;
  logic [QW-1:0]       quot_q;
  logic [KW-1:0]       cnt_q;
  logic [3:0]          step_q;
  logic                second_q;
  logic signed [16:0]  s_q;
  logic signed [38:0]  prod_q;

  logic [CIW-1:0]      ci;
  wave_e               ctype;
  logic signed [15:0]  amp;
  logic [19:0]         p0, p1;
  logic [32:0]         tsum;
  logic [31:0]         tsat, t2;
  logic [20:0]         rem_sh;
  logic                ge;
  logic [DW-1:0]       r_idx;
  logic [DW:0]         rom_addr;
  logic [31:0]         lfsr_nx;
  logic signed [20:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [38:0]  mul_p;
  logic signed [39:0]  rnd_sum;
  logic signed [24:0]  rnd_q;
  logic signed [15:0]  rnd_sat;
  logic signed [18:0]  tot;
  logic signed [19:0]  diff;
  logic [19:0]         adiff;
  logic                emit;
  logic [CNW-1:0]      n_new;

  assign ci    = chan_q[CIW-1:0];
  assign ctype = wave_e'(setup[ci][1:0]);
  assign amp   = setup[ci][17:2];
  assign p0    = setup[ci][37:18];
  assign p1    = setup[ci][57:38];

  assign tsum = {1'b0, time_q[ci]} + {17'd0, elapsed_q};
  assign tsat = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
  assign t2   = (tsat > {12'd0, p0}) ? tsat - {12'd0, p0} : tsat;

  assign rem_sh = {rem_q, div_t_q[31]};
  assign ge     = rem_sh >= {1'b0, p0};

  assign r_idx    = quot_q[DW-1:0];
  assign rom_addr = quot_q[QW-2] ? (DW + 1)'(D) - {1'b0, r_idx} : {1'b0, r_idx};

  always_comb begin
    lfsr_nx = lfsr_q >> 1;
    if (lfsr_q[0]) lfsr_nx = lfsr_nx ^ LfsrMask;
  end

  // shared multiplier operand select
  always_comb begin
    if (state_q == ST_SMUL) begin
      mul_a = 21'(amp);
      mul_b = 18'(s_q);
    end else if (!second_q) begin
      mul_a = signed'({1'b0, p0});
      mul_b = signed'({2'b00, lfsr_q[15:0]} + 18'd32768);
    end else begin
      mul_a = 21'(amp);
      mul_b = signed'({1'b0, lfsr_q[15:0], 1'b1} - 18'd65536);
    end
  end
  assign mul_p = mul_a * mul_b;

  // rounding shift back to 16 bits, 15 for sine and 16 for random
  always_comb begin
    if (state_q == ST_SRND) begin
      rnd_sum = 40'(prod_q) + 40'sd16384;
      rnd_q   = 25'(rnd_sum >>> 15);
    end else begin
      rnd_sum = 40'(prod_q) + 40'sd32768;
      rnd_q   = 25'(rnd_sum >>> 16);
    end
    if (rnd_q > 25'sd32767)       rnd_sat = 16'sh7FFF;
    else if (rnd_q < -25'sd32768) rnd_sat = -16'sh8000;
    else                          rnd_sat = 16'(rnd_q);
  end

  always_comb begin
    if (sum_q > 22'sd262143)       tot = 19'sh3FFFF;
    else if (sum_q < -22'sd262144) tot = -19'sh40000;
    else                           tot = 19'(sum_q);
    diff  = 20'(tot) - 20'(last_q);
    adiff = diff[19] ? 20'(-diff) : 20'(diff);
    emit  = adiff > {4'd0, threshold};
  end

  assign n_new = (int'(channel_count) < N_CHANNELS) ? CNW'(channel_count) : CNW'(N_CHANNELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chan_q    <= '0;
      n_q       <= '0;
      elapsed_q <= '0;
      sum_q     <= '0;
      last_q    <= '0;
      out_q     <= '0;
      m_valid_q <= 1'b0;
      lfsr_q    <= LfsrSeed;
      div_t_q   <= '0;
      rem_q     <= '0;
      quot_q    <= '0;
      cnt_q     <= '0;
      step_q    <= '0;
      second_q  <= 1'b0;
      s_q       <= '0;
      prod_q    <= '0;
      for (int c = 0; c < N_CHANNELS; c++) begin
        time_q[c] <= '0;
        val_q[c]  <= '0;
        intv_q[c] <= '0;
      end
    end else begin
      // a result leaving while a new one is loaded keeps the valid high
      if (m_valid_q && m_axis_tready_i && !(state_q == ST_FINAL && emit)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            elapsed_q <= s_axis_tdata_i[15:0];
            sum_q     <= SW'(signed'(s_axis_tdata_i[31:16]));
            chan_q    <= '0;
            n_q       <= n_new;
            state_q   <= (n_new == '0) ? ST_FINAL : ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q <= ST_NEXT;
          case (ctype)
            WAVE_SINE: begin
              if (p0 == '0) begin
                time_q[ci] <= '0;
                val_q[ci]  <= '0;
              end else begin
                time_q[ci] <= t2;
                div_t_q    <= t2;
                rem_q      <= '0;
                cnt_q      <= '0;
                state_q    <= ST_DIV;
              end
            end
            WAVE_SQUARE: begin
              time_q[ci] <= tsat;
              if (val_q[ci] == amp) begin
                if (tsat > {12'd0, p0}) begin
                  time_q[ci] <= tsat - {12'd0, p0};
                  val_q[ci]  <= '0;
                end
              end else if (tsat > {12'd0, p1}) begin
                time_q[ci] <= tsat - {12'd0, p1};
                val_q[ci]  <= amp;
              end
            end
            WAVE_RANDOM: begin
              if (tsat > {11'd0, intv_q[ci]}) begin
                time_q[ci] <= tsat - {11'd0, intv_q[ci]};
                second_q   <= 1'b0;
                step_q     <= '0;
                state_q    <= ST_DRAW;
              end else begin
                time_q[ci] <= tsat;
              end
            end
            default: begin
              time_q[ci] <= tsat;
              val_q[ci]  <= '0;
            end
          endcase
        end
        ST_DIV: begin
          // one quotient bit per cycle, only the low phase bits are kept
          rem_q   <= ge ? 20'(rem_sh - {1'b0, p0}) : rem_sh[19:0];
          quot_q  <= {quot_q[QW-2:0], ge};
          div_t_q <= div_t_q << 1;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == KW'(DIVN - 1)) state_q <= ST_ROM;
        end
        ST_ROM: begin
          s_q     <= quot_q[QW-1] ? -signed'(sine_rom[rom_addr]) : signed'(sine_rom[rom_addr]);
          state_q <= ST_SMUL;
        end
        ST_SMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_SRND;
        end
        ST_SRND: begin
          val_q[ci] <= rnd_sat;
          state_q   <= ST_NEXT;
        end
        ST_DRAW: begin
          lfsr_q <= lfsr_nx;
          step_q <= step_q + 1'b1;
          if (step_q == 4'hF) state_q <= ST_RMUL;
        end
        ST_RMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_RRES;
        end
        ST_RRES: begin
          if (!second_q) begin
            intv_q[ci] <= prod_q[36:16];
            second_q   <= 1'b1;
            step_q     <= '0;
            state_q    <= ST_DRAW;
          end else begin
            val_q[ci] <= rnd_sat;
            state_q   <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          sum_q <= sum_q + SW'(val_q[ci]);
          if (chan_q + 1'b1 == n_q) begin
            state_q <= ST_FINAL;
          end else begin
            chan_q  <= chan_q + 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_FINAL: begin
          if (!emit) begin
            state_q <= ST_IDLE;
          end else if (!m_valid_q || m_axis_tready_i) begin
            out_q     <= tot;
            last_q    <= tot;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q};

  `DWS_ASSERT_IMP(a_chan_range, clk_i, rst_ni, state_q == ST_LOAD, chan_q < n_q,
                  "channel index past enabled count")
  `DWS_ASSERT_IMP(a_lfsr_live, clk_i, rst_ni, 1'b1, lfsr_q != '0, "lfsr stuck at zero")
  `DWS_ASSERT_IMP(a_out_last, clk_i, rst_ni, m_valid_q, out_q == last_q,
                  "pending result differs from last total")
  `DWS_ASSERT_NXT(a_div_ends, clk_i, rst_ni,
                  state_q == ST_DIV && cnt_q == KW'(DIVN - 1), state_q == ST_ROM,
                  "divider did not hand over to table read")

endmodule
